### sv/vcard_property_line_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef VCARD_PROPERTY_LINE_DECODER_MACROS_SVH
`define VCARD_PROPERTY_LINE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while reset is released.
`define VCPLD_ASSERT(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("vcpld assertion failed");

// Checked on every rising edge, reset included.
`define VCPLD_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("vcpld assertion failed");

`else

`define VCPLD_ASSERT(lbl, clk_sig, rstn_sig, prop)
`define VCPLD_ASSERT_ALWAYS(lbl, clk_sig, prop)

`endif

`endif

### sv/vcpld_pkg.sv
`default_nettype none
package vcpld_pkg;

  localparam int NAME_MAX    = 32;
  localparam int STORE_DEPTH = 32;
  localparam int NAME_CAP    = (NAME_MAX < STORE_DEPTH) ? NAME_MAX : STORE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

  // Command queue depth; must be a power of two so the pointers wrap.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PROP_END = 2'd2,
    KIND_DISCARD  = 2'd3
  } out_kind_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_PASS  = 2'd1,
    MODE_HEX   = 2'd2
  } part_mode_t;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_EMIT  = 2'd1,
    CMD_DUMP  = 2'd2
  } cmd_op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRE,
    BK_MAIN,
    BK_READ,
    BK_NAME
  } back_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       name_truncated;
    logic       last_of_run;
  } out_t;

  // Work handed from the front end to the back end.
  typedef struct packed {
    cmd_op_t          op;
    logic             pre_valid;  // emit a flushed hex byte first
    logic [7:0]       pre_byte;
    out_kind_t        kind;
    logic [7:0]       data;       // result byte, or the name character to store
    logic             trunc;
    logic [LEN_W-1:0] count;      // store address, or name length to dump
  } cmd_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = 4'(c - CH_0);
    end else if (c >= CH_A && c <= CH_F) begin
      d = 4'(c - CH_A) + HEX_TEN;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

### sv/vcpld_fifo.sv
`default_nettype none
`include "vcard_property_line_decoder_macros.svh"
module vcpld_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_en,
  input  vcpld_pkg::cmd_t   wr_data,
  output logic              full,
  input  wire               rd_en,
  output vcpld_pkg::cmd_t   rd_data,
  output logic              empty
);
  import vcpld_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  `VCPLD_ASSERT(a_no_write_when_full, clk, rst_n, !(wr_en && full))
  `VCPLD_ASSERT(a_no_read_when_empty, clk, rst_n, !(rd_en && empty))
  `VCPLD_ASSERT(a_count_bound, clk, rst_n, count_r <= QCNT_W'(QDEPTH))
  `VCPLD_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> empty)

endmodule
`default_nettype wire

### sv/vcpld_front.sv
`default_nettype none
module vcpld_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_push,
  input  wire               in_full,
  input  vcpld_pkg::in_t    in_data,
  output logic              q_wr_en,
  output vcpld_pkg::cmd_t   q_wr_data
);
  import vcpld_pkg::*;

  logic [LEN_W-1:0] name_length_r, name_length_nxt;
  logic             name_closed_r, name_closed_nxt;
  logic             name_overflow_r, name_overflow_nxt;
  logic             in_value_r, in_value_nxt;
  part_mode_t       part_mode_r, part_mode_nxt;
  logic             group_pending_r, group_pending_nxt;
  logic [7:0]       nibble_pair_r, nibble_pair_nxt;
  logic             accept;
  logic             cmd_valid;
  cmd_t             cmd;
  logic [7:0]       c;
  logic             flush;

  assign accept = in_push && !in_full;
  assign c      = in_data.char_byte;
  assign flush  = (part_mode_r == MODE_HEX) && group_pending_r;

  always_comb begin
    name_length_nxt   = name_length_r;
    name_closed_nxt   = name_closed_r;
    name_overflow_nxt = name_overflow_r;
    in_value_nxt      = in_value_r;
    part_mode_nxt     = part_mode_r;
    group_pending_nxt = group_pending_r;
    nibble_pair_nxt   = nibble_pair_r;
    cmd_valid         = 1'b0;
    cmd.op            = CMD_EMIT;
    cmd.pre_valid     = 1'b0;
    cmd.pre_byte      = nibble_pair_r;
    cmd.kind          = KIND_VALUE;
    cmd.data          = c;
    cmd.trunc         = 1'b0;
    cmd.count         = name_length_r;
    if (in_data.req_type) begin
      cmd_valid = 1'b1;
      if (in_value_r) begin
        cmd.pre_valid = flush;
        cmd.kind      = KIND_PROP_END;
        cmd.data      = 8'd0;
        cmd.trunc     = name_overflow_r;
      end else begin
        cmd.kind = KIND_DISCARD;
        cmd.data = 8'd0;
      end
      name_length_nxt   = '0;
      name_closed_nxt   = 1'b0;
      name_overflow_nxt = 1'b0;
      in_value_nxt      = 1'b0;
      part_mode_nxt     = MODE_START;
      group_pending_nxt = 1'b0;
      nibble_pair_nxt   = 8'd0;
    end else if (!in_value_r) begin
      if (c == CH_COLON) begin
        // An empty name gives nothing to dump.
        cmd_valid         = (name_length_r != '0);
        cmd.op            = CMD_DUMP;
        in_value_nxt      = 1'b1;
        part_mode_nxt     = MODE_START;
        group_pending_nxt = 1'b0;
        nibble_pair_nxt   = 8'd0;
      end else if (!name_closed_r) begin
        if (c == CH_SEMI) begin
          name_closed_nxt = 1'b1;
        end else if (name_length_r < LEN_W'(NAME_CAP)) begin
          cmd_valid       = 1'b1;
          cmd.op          = CMD_STORE;
          name_length_nxt = name_length_r + 1'b1;
        end else begin
          name_overflow_nxt = 1'b1;
        end
      end
    end else if (c == CH_SEMI) begin
      cmd_valid         = 1'b1;
      cmd.pre_valid     = flush;
      cmd.data          = CH_SPACE;
      part_mode_nxt     = MODE_START;
      group_pending_nxt = 1'b0;
      nibble_pair_nxt   = 8'd0;
    end else begin
      unique case (part_mode_r)
        MODE_START: begin
          if (c == CH_EQ) begin
            part_mode_nxt     = MODE_HEX;
            group_pending_nxt = 1'b0;
            nibble_pair_nxt   = 8'd0;
          end else begin
            part_mode_nxt = MODE_PASS;
            cmd_valid     = 1'b1;
          end
        end
        MODE_HEX: begin
          if (c == CH_EQ) begin
            cmd_valid         = group_pending_r;
            cmd.data          = nibble_pair_r;
            group_pending_nxt = 1'b0;
            nibble_pair_nxt   = 8'd0;
          end else begin
            nibble_pair_nxt   = {nibble_pair_r[3:0], hex_digit(c)};
            group_pending_nxt = 1'b1;
          end
        end
        default: begin
          cmd_valid = 1'b1;
        end
      endcase
    end
  end

  assign q_wr_en   = accept && cmd_valid;
  assign q_wr_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_length_r   <= '0;
      name_closed_r   <= 1'b0;
      name_overflow_r <= 1'b0;
      in_value_r      <= 1'b0;
      part_mode_r     <= MODE_START;
      group_pending_r <= 1'b0;
      nibble_pair_r   <= 8'd0;
    end else if (accept) begin
      name_length_r   <= name_length_nxt;
      name_closed_r   <= name_closed_nxt;
      name_overflow_r <= name_overflow_nxt;
      in_value_r      <= in_value_nxt;
      part_mode_r     <= part_mode_nxt;
      group_pending_r <= group_pending_nxt;
      nibble_pair_r   <= nibble_pair_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/vcpld_back.sv
`default_nettype none
`include "vcard_property_line_decoder_macros.svh"
module vcpld_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_empty,
  input  vcpld_pkg::cmd_t   q_rd_data,
  output logic              q_rd_en,
  output logic              empty,
  input  wire               pop,
  output vcpld_pkg::out_t   out_data
);
  import vcpld_pkg::*;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [7:0]        name_mem [STORE_DEPTH];
  logic [7:0]        rd_data_r;
  out_t              out_r, out_nxt;
  logic              out_valid_r;
  logic              out_load;
  logic              slot_free;
  logic              done;
  logic              take;
  logic              name_last;

  assign slot_free = !out_valid_r || pop;
  assign name_last = ({1'b0, idx_r} == (cmd_r.count - 1'b1));

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    out_load  = 1'b0;
    out_nxt   = out_r;
    done      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        done = 1'b1;
      end
      BK_PRE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          out_nxt   = '{out_kind: KIND_VALUE, out_byte: cmd_r.pre_byte,
                        name_truncated: 1'b0, last_of_run: 1'b0};
          state_nxt = BK_MAIN;
        end
      end
      BK_MAIN: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_nxt  = '{out_kind: cmd_r.kind, out_byte: cmd_r.data,
                       name_truncated: cmd_r.trunc, last_of_run: 1'b1};
          done     = 1'b1;
        end
      end
      BK_READ: begin
        state_nxt = BK_NAME;
      end
      BK_NAME: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_nxt  = '{out_kind: KIND_NAME, out_byte: rd_data_r,
                       name_truncated: 1'b0, last_of_run: name_last};
          if (name_last) begin
            done = 1'b1;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = BK_READ;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    take = done && !q_empty;
    if (done) begin
      state_nxt = BK_IDLE;
    end
    if (take) begin
      cmd_nxt = q_rd_data;
      unique case (q_rd_data.op)
        CMD_STORE: state_nxt = BK_IDLE;
        CMD_EMIT:  state_nxt = q_rd_data.pre_valid ? BK_PRE : BK_MAIN;
        CMD_DUMP: begin
          idx_nxt   = '0;
          state_nxt = BK_READ;
        end
        default:   state_nxt = BK_IDLE;
      endcase
    end
  end

  assign q_rd_en  = take;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_rd_data.op == CMD_STORE) begin
      name_mem[q_rd_data.count[ADDR_W-1:0]] <= q_rd_data.data;
    end
    if (state_r == BK_READ) begin
      rd_data_r <= name_mem[idx_r];
    end
  end

  `VCPLD_ASSERT(a_read_then_name, clk, rst_n, state_r == BK_READ |=> state_r == BK_NAME)
  `VCPLD_ASSERT(a_name_idx_in_range, clk, rst_n,
    state_r == BK_NAME |-> ({1'b0, idx_r} < cmd_r.count))

endmodule
`default_nettype wire

### sv/vcard_property_line_decoder.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// input     in         push / full        in_data  (req_type, char_byte)
// result    out        empty / pop        out_data (out_kind, out_byte,
//                                                   name_truncated, last_of_run)
//
// One character is taken per cycle while the command queue has room; a result
// with a single value byte also leaves at one per cycle while pop keeps up.
// A colon dumps the buffered name byte by byte, each byte paced by the registered
// read of the name memory; the front keeps accepting into the queue meanwhile.
// Reset is synchronous and active low; it clears all line state, the queue and
// the result valid flag. The name memory needs no clearing pass.
// A stalled pop holds the result register; the queue fills and then raises full.
module vcard_property_line_decoder (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  output logic             full,
  input  vcpld_pkg::in_t   in_data,
  output logic             empty,
  input  wire              pop,
  output vcpld_pkg::out_t  out_data
);
  import vcpld_pkg::*;

  // Commands travel from the front end, which tracks the line state, to the
  // back end, which owns the name memory and produces the result transactions.
  logic q_wr_en;
  cmd_t q_wr_data;
  logic q_full;
  logic q_rd_en;
  cmd_t q_rd_data;
  logic q_empty;

  assign full = q_full;

  // Front end: classifies each character and keeps the per-line state.
  vcpld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (push),
    .in_full   (q_full),
    .in_data   (in_data),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  // Short queue so the two halves can stall independently.
  vcpld_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Back end: stores name characters, replays the name at the colon, and
  // emits value bytes and line markers through one output register.
  vcpld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rd_data (q_rd_data),
    .q_rd_en   (q_rd_en),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcpld_pkg::*;

  // Clock, reset and the two queue-style channels of the decoder.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data;

  vcard_property_line_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // The run is ended here if the decoder ever stops making progress.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Percentages of cycles in which the sender or the receiver holds back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Bookkeeping for the summary and the verdict.
  int err_count = 0;
  int items_sent = 0;
  int lines_sent = 0;
  int results_seen = 0;
  int truncated_ends = 0;

  // Decoded results that the block still owes us, oldest first.
  out_t decoded_q[$];

  // Our own copy of the per-line decoder state.
  logic [7:0] name_mem [0:STORE_DEPTH-1];
  int name_len;
  logic name_closed;
  logic name_overflow;
  logic in_value;
  part_mode_t part_mode;
  logic group_pending;
  logic [7:0] nibble_pair;

  // The receiver draws a fresh pop decision on every rising edge, so gaps land on
  // every phase of a name dump or a value burst.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic out_t result_of(input out_kind_t kind, input logic [7:0] data,
                                     input logic trunc);
    out_t r;
    r.out_kind = kind;
    r.out_byte = data;
    r.name_truncated = trunc;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Digits 0-9 and A-F count; lowercase and anything else decode as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      n = c[3:0];
    end else if (c >= CH_A && c <= CH_F) begin
      n = 4'(c - CH_A) + HEX_TEN;
    end
    return n;
  endfunction

  task automatic clear_line_state();
    name_len = 0;
    name_closed = 1'b0;
    name_overflow = 1'b0;
    in_value = 1'b0;
    part_mode = MODE_START;
    group_pending = 1'b0;
    nibble_pair = 8'h00;
  endtask

  // A pending hex group turns into one byte made of its last two digits.
  task automatic flush_group(inout out_t res[$]);
    if (group_pending) begin
      res.insert(res.size(), result_of(KIND_VALUE, nibble_pair, 1'b0));
    end
    group_pending = 1'b0;
    nibble_pair = 8'h00;
  endtask

  // Works out every result that one accepted transaction causes and queues it.
  task automatic decode_item(input in_t it);
    out_t res[$];
    logic [7:0] c;
    c = it.char_byte;
    if (it.req_type) begin
      // End of line: a property end if the colon was seen, a discard otherwise.
      if (in_value) begin
        if (part_mode == MODE_HEX) begin
          flush_group(res);
        end
        res.insert(res.size(), result_of(KIND_PROP_END, 8'h00, name_overflow));
        if (name_overflow) begin
          truncated_ends++;
        end
      end else begin
        res.insert(res.size(), result_of(KIND_DISCARD, 8'h00, 1'b0));
      end
      clear_line_state();
    end else if (!in_value) begin
      if (c == CH_COLON) begin
        // The colon dumps the buffered name; an empty name gives nothing.
        for (int i = 0; i < name_len; i++) begin
          res.insert(res.size(), result_of(KIND_NAME, name_mem[i], 1'b0));
        end
        in_value = 1'b1;
        part_mode = MODE_START;
        group_pending = 1'b0;
        nibble_pair = 8'h00;
      end else if (!name_closed) begin
        if (c == CH_SEMI) begin
          name_closed = 1'b1;
        end else if (name_len < NAME_CAP) begin
          name_mem[name_len] = c;
          name_len++;
        end else begin
          name_overflow = 1'b1;
        end
      end
    end else if (c == CH_SEMI) begin
      // A semicolon closes the value part and comes out as a space.
      if (part_mode == MODE_HEX) begin
        flush_group(res);
      end
      res.insert(res.size(), result_of(KIND_VALUE, CH_SPACE, 1'b0));
      part_mode = MODE_START;
    end else begin
      case (part_mode)
        MODE_START: begin
          if (c == CH_EQ) begin
            part_mode = MODE_HEX;
            group_pending = 1'b0;
            nibble_pair = 8'h00;
          end else begin
            part_mode = MODE_PASS;
            res.insert(res.size(), result_of(KIND_VALUE, c, 1'b0));
          end
        end
        MODE_HEX: begin
          if (c == CH_EQ) begin
            flush_group(res);
          end else begin
            // Only the last two digits survive; older ones shift out.
            nibble_pair = {nibble_pair[3:0], nibble_of(c)};
            group_pending = 1'b1;
          end
        end
        default: begin
          res.insert(res.size(), result_of(KIND_VALUE, c, 1'b0));
        end
      endcase
    end
    if (res.size() > 0) begin
      res[res.size()-1].last_of_run = 1'b1;
    end
    foreach (res[i]) begin
      decoded_q.insert(decoded_q.size(), res[i]);
    end
  endtask

  function automatic int field_check(input string fld, input logic [7:0] want,
                                     input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, fld, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Every result transaction is checked against the oldest outstanding
  // prediction. Sampling at the falling edge sees the values that the next
  // rising edge will use, since both sides only change right after a rising edge.
  always @(negedge clk) begin
    out_t want;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual kind %0h byte %0h",
                 $realtime, out_data.out_kind, out_data.out_byte);
      end else begin
        want = decoded_q.pop_front();
        err_count += field_check("out_kind", 8'(want.out_kind), 8'(out_data.out_kind));
        err_count += field_check("out_byte", want.out_byte, out_data.out_byte);
        err_count += field_check("name_truncated", 8'(want.name_truncated),
                                 8'(out_data.name_truncated));
        err_count += field_check("last_of_run", 8'(want.last_of_run),
                                 8'(out_data.last_of_run));
      end
    end
  end

  // Sends one input transaction. It is called right after a rising edge; the
  // sender may first hold back for a random stretch. The decision whether the
  // edge takes the item is read at the falling edge before it, because full
  // cannot change in between.
  task automatic send_item(input logic req, input logic [7:0] ch);
    in_t it;
    logic taken;
    it.req_type = req;
    it.char_byte = ch;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    forever begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
      if (taken) begin
        break;
      end
    end
    items_sent++;
    decode_item(it);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(1'b0, c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  // The character that rides along with an end of line is ignored, so it is random.
  task automatic end_line();
    send_item(1'b1, 8'($urandom_range(255)));
    lines_sent++;
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_COLON || c == CH_SEMI);
    return c;
  endfunction

  // Mostly real hex digits, some lowercase, now and then any byte but a separator.
  function automatic logic [7:0] hex_char();
    string upper_set;
    string lower_set;
    int pick;
    logic [7:0] c;
    upper_set = "0123456789ABCDEF";
    lower_set = "abcdef";
    pick = $urandom_range(9);
    if (pick < 6) begin
      c = upper_set[$urandom_range(15)];
    end else if (pick < 8) begin
      c = lower_set[$urandom_range(5)];
    end else begin
      do begin
        c = 8'($urandom_range(255));
      end while (c == CH_EQ || c == CH_SEMI);
    end
    return c;
  endfunction

  function automatic logic [7:0] pass_char(input logic first);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_SEMI || (first && c == CH_EQ));
    return c;
  endfunction

  // One random line. Most are well formed with random content: a name, maybe
  // parameters, a colon, then hex, pass-through and empty value parts. Some
  // lines lack the colon, and a few items are plain noise.
  task automatic random_line();
    int pick;
    int name_n;
    int parts;
    int groups;
    int len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      return;
    end
    len = $urandom_range(99);
    if (len < 55) begin
      name_n = $urandom_range(8);
    end else if (len < 75) begin
      name_n = $urandom_range(NAME_CAP - 1, 9);
    end else begin
      // Right at the capacity of the name buffer and a little past it.
      name_n = $urandom_range(NAME_CAP + 3, NAME_CAP - 1);
    end
    for (int i = 0; i < name_n; i++) begin
      send_char(name_char());
    end
    if ($urandom_range(99) < 30) begin
      send_char(CH_SEMI);
      len = $urandom_range(5);
      for (int i = 0; i < len; i++) begin
        send_char(($urandom_range(3) == 0) ? CH_SEMI : name_char());
      end
    end
    if (pick < 18) begin
      end_line();
      return;
    end
    send_char(CH_COLON);
    parts = $urandom_range(4);
    for (int p = 0; p < parts; p++) begin
      if (p > 0) begin
        send_char(CH_SEMI);
      end
      case ($urandom_range(2))
        0: begin
          send_char(CH_EQ);
          groups = $urandom_range(3);
          for (int g = 0; g < groups; g++) begin
            if (g > 0) begin
              send_char(CH_EQ);
            end
            len = $urandom_range(4);
            for (int i = 0; i < len; i++) begin
              send_char(hex_char());
            end
          end
        end
        1: begin
          len = $urandom_range(6, 1);
          for (int i = 0; i < len; i++) begin
            send_char(pass_char(i == 0));
          end
        end
        default: begin
          // An empty part: two semicolons in a row.
        end
      endcase
    end
    end_line();
  endtask

  // Hand-picked lines: a bare end of line, names with extreme bytes and a
  // parameter tail, hex groups with lowercase, long and empty groups, a bare
  // equals part, a colon and an all-ones byte inside the value, a hex group
  // left open at end of line, an empty name, and a line without a colon.
  task automatic test_directed_cases();
    end_line();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_SEMI);
    send_text("x");
    send_char(CH_COLON);
    send_text("=1aF=9;");
    send_text("==");
    send_char(CH_SEMI);
    send_char(CH_COLON);
    send_char(8'hFF);
    send_text(";=7");
    end_line();
    send_char(CH_COLON);
    end_line();
    send_text("X");
    end_line();
  endtask

  // Random lines under one pattern of sender and receiver gaps, until about
  // item_goal transactions have gone in.
  task automatic test_random_lines(input int send_pct, input int recv_pct,
                                   input int item_goal);
    int start;
    start = items_sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (items_sent - start < item_goal) begin
      random_line();
    end
  endtask

  initial begin
    clear_line_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_lines(34, 60, 70);
    test_random_lines(60, 34, 70);
    test_random_lines(0, 0, 70);

    // Let the block drain, then watch a while longer for stray results.
    push <= 1'b0;
    recv_idle_pct = 0;
    wait (decoded_q.size() == 0);
    repeat (200) @(posedge clk);

    $display("Sent %0d items in %0d lines and checked %0d results,", items_sent,
             lines_sent, results_seen);
    $display("%0d of the property ends reported a truncated name.", truncated_ends);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/vcpld_pkg.sv
sv/vcpld_fifo.sv
sv/vcpld_front.sv
sv/vcpld_back.sv
sv/vcard_property_line_decoder.sv
sim/tb.sv
